[design/sha_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package sha_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_queue_head;

    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

endpackage
`default_nettype wire

[design/sha_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module sha_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire sha_pkg::t_item i_item,
    output sha_pkg::t_queue_head o_head,
    input  wire logic           i_pop
);
    sha_pkg::t_item r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           w_push;
    logic           w_pop;

    assign o_ready = (r_cnt != 2'd2);
    // items that carry neither a byte nor an end mark do nothing, so they are dropped here
    assign w_push  = i_valid && o_ready && (i_item.byte_valid || i_item.end_of_message);
    assign w_pop   = i_pop && (r_cnt != 2'd0);

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_mem[r_wp] <= i_item;
                r_wp        <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule
`default_nettype wire

[design/sha_core.sv]
`timescale 1ns / 1ps
`default_nettype none
module sha_core (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire sha_pkg::t_queue_head i_head,
    output logic                      o_pop,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [31:0]               o_digest_word,
    output logic [2:0]                o_word_index,
    output logic                      o_final_word
);
    typedef enum logic [2:0] {S_IDLE, S_PAD, S_ROUND, S_FOLD, S_OUT} t_state;

    t_state      r_state;
    t_state      r_ret;
    logic [31:0] r_w [16];
    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [5:0]  r_fill;
    logic [63:0] r_bitlen;
    logic [5:0]  r_rnd;
    logic        r_mark_sent;
    logic        r_len;
    logic [2:0]  r_oidx;
    logic        r_out_valid;
    logic [31:0] r_out_word;
    logic [2:0]  r_out_idx;
    logic        r_out_final;

    logic        w_push;
    logic [7:0]  w_push_byte;
    logic [7:0]  w_pad_byte;
    logic [7:0]  w_len_byte;
    logic        w_len_now;
    logic        w_fill_wrap;
    logic [2:0]  w_len_sel;
    logic [31:0] w_t1;
    logic [31:0] w_t2;
    logic [31:0] w_sched;
    logic [31:0] w_choose;
    logic [31:0] w_major;
    logic        w_load;

    assign o_pop         = (r_state == S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_digest_word = r_out_word;
    assign o_word_index  = r_out_idx;
    assign o_final_word  = r_out_final;

    always_comb begin
        w_fill_wrap = (r_fill == 6'd63);
        // length bytes occupy offsets 56..63, most significant first
        w_len_now   = r_mark_sent && (r_len || (r_fill == 6'd56));
        w_len_sel   = ~r_fill[2:0];
        w_len_byte  = r_bitlen[{w_len_sel, 3'b000} +: 8];
        w_pad_byte  = !r_mark_sent ? sha_pkg::PAD_MARK : (w_len_now ? w_len_byte : 8'h00);
        w_push      = ((r_state == S_IDLE) && i_head.valid && i_head.item.byte_valid)
                      || (r_state == S_PAD);
        w_push_byte = (r_state == S_PAD) ? w_pad_byte : i_head.item.data_byte;
        w_load      = (r_state == S_OUT) && (!r_out_valid || i_ready);

        w_choose = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        w_major  = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        w_t1     = r_v[7] + sha_pkg::big_sigma1(r_v[4]) + w_choose
                   + sha_pkg::ROUND_K[r_rnd] + r_w[0];
        w_t2     = sha_pkg::big_sigma0(r_v[0]) + w_major;
        w_sched  = sha_pkg::small_sigma1(r_w[14]) + r_w[9]
                   + sha_pkg::small_sigma0(r_w[1]) + r_w[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= S_IDLE;
            r_h         <= sha_pkg::IV;
            r_fill      <= 6'd0;
            r_bitlen    <= 64'd0;
            r_rnd       <= 6'd0;
            r_mark_sent <= 1'b0;
            r_len       <= 1'b0;
            r_oidx      <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_push) begin
                r_w[r_fill[5:2]][{~r_fill[1:0], 3'b000} +: 8] <= w_push_byte;
                r_fill <= r_fill + 6'd1;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_head.valid) begin
                        r_mark_sent <= 1'b0;
                        r_len       <= 1'b0;
                        if (i_head.item.byte_valid) begin
                            r_bitlen <= r_bitlen + 64'd8;
                        end
                        if (i_head.item.byte_valid && w_fill_wrap) begin
                            r_state <= S_ROUND;
                            r_v     <= r_h;
                            r_rnd   <= 6'd0;
                            r_ret   <= i_head.item.end_of_message ? S_PAD : S_IDLE;
                        end else if (i_head.item.end_of_message) begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    r_mark_sent <= 1'b1;
                    if (w_len_now) begin
                        r_len <= 1'b1;
                    end
                    if (w_fill_wrap) begin
                        r_state <= S_ROUND;
                        r_v     <= r_h;
                        r_rnd   <= 6'd0;
                        r_ret   <= w_len_now ? S_OUT : S_PAD;
                        r_oidx  <= 3'd0;
                    end
                end
                S_ROUND: begin
                    r_v[7] <= r_v[6];
                    r_v[6] <= r_v[5];
                    r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + w_t1;
                    r_v[3] <= r_v[2];
                    r_v[2] <= r_v[1];
                    r_v[1] <= r_v[0];
                    r_v[0] <= w_t1 + w_t2;
                    for (int i = 0; i < 15; i++) begin
                        r_w[i] <= r_w[i + 1];
                    end
                    r_w[15] <= w_sched;
                    r_rnd   <= r_rnd + 6'd1;
                    if (r_rnd == 6'd63) begin
                        r_state <= S_FOLD;
                    end
                end
                S_FOLD: begin
                    for (int i = 0; i < 8; i++) begin
                        r_h[i] <= r_h[i] + r_v[i];
                    end
                    r_state <= r_ret;
                end
                S_OUT: begin
                    if (w_load) begin
                        r_out_word  <= r_h[r_oidx];
                        r_out_idx   <= r_oidx;
                        r_out_final <= (r_oidx == 3'd7);
                        r_oidx      <= r_oidx + 3'd1;
                        if (r_oidx == 3'd7) begin
                            r_h      <= sha_pkg::IV;
                            r_fill   <= 6'd0;
                            r_bitlen <= 64'd0;
                            r_state  <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

[design/sha256_hash.sv]
`timescale 1ns / 1ps
`default_nettype none
// channel  direction  handshake          payload
// in       input      i_valid / o_ready  i_data_byte, i_byte_valid, i_end_of_message
// out      output     o_valid / i_ready  o_digest_word, o_word_index, o_final_word
//
// A byte is stored while the core is idle; the 64th byte of a block starts 64 rounds
// at one per cycle, then a fold into the chain. The end mark pads one byte per cycle
// while no block is hashed (up to two extra blocks), then sends 8 words.
// Reset (synchronous, active low) loads the initial hash value and clears counters.
// A two-entry queue takes up to two transfers while the round engine is busy.
module sha256_hash (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_byte_valid,
    input  wire logic        i_end_of_message,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_digest_word,
    output logic [2:0]       o_word_index,
    output logic             o_final_word
);
    sha_pkg::t_item       w_item;
    sha_pkg::t_queue_head w_head;
    logic                 w_pop;

    assign w_item.data_byte      = i_data_byte;
    assign w_item.byte_valid     = i_byte_valid;
    assign w_item.end_of_message = i_end_of_message;

    sha_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (w_item),
        .o_head  (w_head),
        .i_pop   (w_pop)
    );

    sha_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (w_head),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_final_word  (o_final_word)
    );
endmodule
`default_nettype wire
